// File: hdl/qte_pkg.sv
// ============================================================================
// Quaternion to Euler angle package
// Shared widths, pipeline depths, angle constants and the CORDIC angle table.
// ============================================================================
package qte_pkg;

    localparam int COMP_W        = 16;
    localparam int PROD_W        = 2 * COMP_W;
    localparam int TERM_W        = 34;
    localparam int ROOT_W        = 29;
    localparam int SQRT_W        = 58;
    localparam int SQRT_STEPS    = 29;
    localparam int XY_N          = 42;
    localparam int XY_W          = 45;
    localparam int Z_W           = 27;
    localparam int CORDIC_STEPS  = 22;
    localparam int CORDIC_LAT    = CORDIC_STEPS + 4;
    localparam int PITCH_LEAD    = SQRT_STEPS + 2;
    localparam int LATENCY       = PITCH_LEAD + CORDIC_LAT + 3;
    localparam int SIDE_LEN      = SQRT_STEPS + CORDIC_LAT + 2;
    localparam int ANG_W         = 16;
    localparam int PITCH_W       = 15;
    localparam int ANG_FRAC      = 16;
    localparam int OUT_FRAC      = 7;
    localparam int ROUND_SH      = ANG_FRAC - OUT_FRAC;
    localparam int Q_FRAC        = 14;

    localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'sd1 <<< (2 * Q_FRAC));
    localparam logic [SQRT_W-1:0]        ONE_Q56 = SQRT_W'(64'd1 << (4 * Q_FRAC));
    localparam logic signed [Z_W-1:0]    DEG180  = Z_W'(64'sd180 <<< ANG_FRAC);
    localparam logic signed [ANG_W-1:0]  DEG90_OUT = ANG_W'(64'sd90 <<< OUT_FRAC);

    localparam logic signed [Z_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
        27'sd117304, 27'sd58666, 27'sd29335, 27'sd14668, 27'sd7334,
        27'sd3667, 27'sd1833, 27'sd917, 27'sd458, 27'sd229, 27'sd115,
        27'sd57, 27'sd29, 27'sd14, 27'sd7, 27'sd4, 27'sd2
    };

    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

endpackage

// File: hdl/quaternion_to_euler_degrees_core.sv
// ============================================================================
// Quaternion to Euler angles, Z-Y-X order, in degrees
// Fully pipelined: products, terms, a restoring square root for the pitch
// cosine and three vectoring CORDIC arctangent units.
// ============================================================================
// Usage:
// One quaternion (quat_x, quat_y, quat_z, quat_w, signed Q2.14) enters per
// input transaction on in_valid/in_ready. Each input transaction produces
// exactly one output transaction on out_valid/out_ready carrying roll_deg,
// pitch_deg and yaw_deg in degrees with 7 fraction bits, and pitch_saturated,
// which is set when |2(wy - zx)| reaches one and pitch is clamped to 90 deg.
// The pipeline has 60 register stages. Throughput is one transaction per
// cycle while the output is not stalled; the depth is set by the 29-step
// square root and the 26-stage CORDIC that follow each other on the pitch
// path, with roll and yaw delayed to match.
// The whole pipeline advances together. When the receiver holds out_ready low
// with a result waiting, every stage holds and in_ready drops; empty stages
// are refilled as soon as the output moves. Reset clears all valid bits, so
// the pipeline starts empty; the data registers are not reset.
// ============================================================================
module quaternion_to_euler_degrees_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] roll_deg,
    output logic signed [14:0] pitch_deg,
    output logic signed [15:0] yaw_deg,
    output logic               pitch_saturated
);
    import qte_pkg::*;

    logic                     adv;
    logic                     vld_reg [0:LATENCY-1];
    logic signed [PROD_W-1:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [PROD_W-1:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;
    term_t                    sinr_reg, cosr_reg, siny_reg, cosy_reg, sinp_reg;
    term_t                    sinr_next, cosr_next, siny_next, cosy_next, sinp_next;
    logic signed [ROOT_W-1:0] ps_reg;
    logic signed [ROOT_W-1:0] pr_reg;
    logic        [SQRT_W-1:0] sq_reg;
    logic signed [SQRT_W-1:0] sq_next;
    logic        [SQRT_W-1:0] rem_val;
    logic        [SQRT_W-1:0] sv_reg [0:SQRT_STEPS-1];
    logic        [SQRT_W-1:0] sr_reg [0:SQRT_STEPS-1];
    logic signed [ROOT_W-1:0] ss_reg [0:SQRT_STEPS-1];
    logic        [SQRT_W-1:0] sv_next [0:SQRT_STEPS-1];
    logic        [SQRT_W-1:0] sr_next [0:SQRT_STEPS-1];
    logic                     sat_reg [0:SIDE_LEN-1];
    logic                     neg_reg [0:SIDE_LEN-1];
    angle_t                   roll_dly_reg [0:PITCH_LEAD-1];
    angle_t                   yaw_dly_reg [0:PITCH_LEAD-1];
    angle_t                   roll_ang, yaw_ang, pitch_ang;
    angle_t                   pitch_next;
    term_t                    p_sin_in, p_cos_in;
    logic signed [ANG_W-1:0]  roll_reg, yaw_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic                     psat_reg;

    assign adv       = !vld_reg[LATENCY-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATENCY; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LATENCY; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_comb
    begin
        sinr_next = (TERM_W'(p_wx_reg) + TERM_W'(p_yz_reg)) <<< 1;
        cosr_next = ONE_Q28 - ((TERM_W'(p_xx_reg) + TERM_W'(p_yy_reg)) <<< 1);
        siny_next = (TERM_W'(p_wz_reg) + TERM_W'(p_xy_reg)) <<< 1;
        cosy_next = ONE_Q28 - ((TERM_W'(p_yy_reg) + TERM_W'(p_zz_reg)) <<< 1);
        sinp_next = (TERM_W'(p_wy_reg) - TERM_W'(p_zx_reg)) <<< 1;
        sq_next   = SQRT_W'(pr_reg * pr_reg);
        rem_val   = ONE_Q56 - sq_reg;
    end

    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            logic [SQRT_W-1:0] v;
            logic [SQRT_W-1:0] r;
            logic [SQRT_W-1:0] b;
            v = (k == 0) ? rem_val : sv_reg[(k == 0) ? 0 : k-1];
            r = (k == 0) ? '0 : sr_reg[(k == 0) ? 0 : k-1];
            b = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - k));
            if (v >= r + b)
            begin
                sv_next[k] = v - (r + b);
                sr_next[k] = (r >> 1) + b;
            end
            else
            begin
                sv_next[k] = v;
                sr_next[k] = r >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_wx_reg <= quat_w * quat_x;
            p_yz_reg <= quat_y * quat_z;
            p_xx_reg <= quat_x * quat_x;
            p_yy_reg <= quat_y * quat_y;
            p_wz_reg <= quat_w * quat_z;
            p_xy_reg <= quat_x * quat_y;
            p_zz_reg <= quat_z * quat_z;
            p_wy_reg <= quat_w * quat_y;
            p_zx_reg <= quat_z * quat_x;
            sinr_reg <= sinr_next;
            cosr_reg <= cosr_next;
            siny_reg <= siny_next;
            cosy_reg <= cosy_next;
            sinp_reg <= sinp_next;
            pr_reg   <= sinp_reg[ROOT_W-1:0];
            sat_reg[0] <= (sinp_reg >= ONE_Q28) || (sinp_reg <= -ONE_Q28);
            neg_reg[0] <= (sinp_reg < 0);
            for (int i = 1; i < SIDE_LEN; i++)
            begin
                sat_reg[i] <= sat_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
            sq_reg  <= sq_next;
            ps_reg  <= pr_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sv_reg[k] <= sv_next[k];
                sr_reg[k] <= sr_next[k];
                ss_reg[k] <= (k == 0) ? ps_reg : ss_reg[(k == 0) ? 0 : k-1];
            end
            roll_dly_reg[0] <= roll_ang;
            yaw_dly_reg[0]  <= yaw_ang;
            for (int i = 1; i < PITCH_LEAD; i++)
            begin
                roll_dly_reg[i] <= roll_dly_reg[i-1];
                yaw_dly_reg[i]  <= yaw_dly_reg[i-1];
            end
            roll_reg  <= roll_dly_reg[PITCH_LEAD-1];
            yaw_reg   <= yaw_dly_reg[PITCH_LEAD-1];
            pitch_reg <= pitch_next[PITCH_W-1:0];
            psat_reg  <= sat_reg[SIDE_LEN-1];
        end
    end

    assign p_sin_in = {{(TERM_W-ROOT_W){ss_reg[SQRT_STEPS-1][ROOT_W-1]}},
                       ss_reg[SQRT_STEPS-1]};
    assign p_cos_in = {{(TERM_W-ROOT_W){1'b0}}, sr_reg[SQRT_STEPS-1][ROOT_W-1:0]};

    always_comb
    begin
        pitch_next = pitch_ang;
        if (pitch_next > DEG90_OUT)
        begin
            pitch_next = DEG90_OUT;
        end
        if (pitch_next < -DEG90_OUT)
        begin
            pitch_next = -DEG90_OUT;
        end
        if (sat_reg[SIDE_LEN-1])
        begin
            pitch_next = neg_reg[SIDE_LEN-1] ? -DEG90_OUT : DEG90_OUT;
        end
    end

    qte_cordic u_roll (
        .clk     (clk),
        .en      (adv),
        .sin_val (sinr_reg),
        .cos_val (cosr_reg),
        .angle   (roll_ang)
    );

    qte_cordic u_yaw (
        .clk     (clk),
        .en      (adv),
        .sin_val (siny_reg),
        .cos_val (cosy_reg),
        .angle   (yaw_ang)
    );

    qte_cordic u_pitch (
        .clk     (clk),
        .en      (adv),
        .sin_val (p_sin_in),
        .cos_val (p_cos_in),
        .angle   (pitch_ang)
    );

    assign roll_deg        = roll_reg;
    assign yaw_deg         = yaw_reg;
    assign pitch_deg       = pitch_reg;
    assign pitch_saturated = psat_reg;

endmodule

// File: hdl/qte_cordic.sv
// ============================================================================
// Pipelined vectoring CORDIC arctangent
// Folds the vector into the right half plane, normalizes it, runs one CORDIC
// rotation per stage and rounds the angle to degrees with 7 fraction bits.
// ============================================================================
module qte_cordic (
    input  logic            clk,
    input  logic            en,
    input  qte_pkg::term_t  sin_val,
    input  qte_pkg::term_t  cos_val,
    output qte_pkg::angle_t angle
);
    import qte_pkg::*;

    localparam int ZN = CORDIC_STEPS + 3;

    logic signed [XY_N-1:0] nx_reg [0:2];
    logic signed [XY_N-1:0] ny_reg [0:2];
    logic        [XY_N-1:0] nm_reg [0:2];
    logic signed [XY_N-1:0] nx_next [1:2];
    logic signed [XY_N-1:0] ny_next [1:2];
    logic        [XY_N-1:0] nm_next [1:2];
    logic signed [XY_W-1:0] x_reg [0:CORDIC_STEPS-1];
    logic signed [XY_W-1:0] y_reg [0:CORDIC_STEPS-1];
    logic signed [XY_W-1:0] x_next [0:CORDIC_STEPS-1];
    logic signed [XY_W-1:0] y_next [0:CORDIC_STEPS-1];
    logic signed [Z_W-1:0]  z_reg [0:ZN-1];
    logic signed [Z_W-1:0]  z_next [0:CORDIC_STEPS-1];
    logic                   spec_reg [0:ZN-1];
    logic                   sneg_reg [0:ZN-1];
    logic signed [XY_N-1:0] a_ext;
    logic signed [XY_N-1:0] b_ext;
    logic signed [XY_N-1:0] f_x;
    logic signed [XY_N-1:0] f_y;
    logic signed [Z_W-1:0]  f_z;
    logic        [XY_N-1:0] mag_x;
    logic        [XY_N-1:0] mag_y;
    logic signed [Z_W-1:0]  z_clamp;
    logic signed [Z_W-1:0]  z_round;
    angle_t                 angle_reg;
    angle_t                 angle_next;

    always_comb
    begin
        a_ext = {{(XY_N-TERM_W){cos_val[TERM_W-1]}}, cos_val};
        b_ext = {{(XY_N-TERM_W){sin_val[TERM_W-1]}}, sin_val};
        f_x   = a_ext;
        f_y   = b_ext;
        f_z   = '0;
        if (a_ext < 0)
        begin
            f_x = -a_ext;
            f_y = -b_ext;
            f_z = (b_ext >= 0) ? DEG180 : -DEG180;
        end
        mag_x = f_x;
        mag_y = (f_y < 0) ? XY_N'(-f_y) : XY_N'(f_y);
    end

    always_comb
    begin
        for (int s = 1; s < 3; s++)
        begin
            nx_next[s] = nx_reg[s-1];
            ny_next[s] = ny_reg[s-1];
            nm_next[s] = nm_reg[s-1];
            for (int j = 0; j < 3; j++)
            begin
                if (nm_next[s] < (XY_N'(1) << (XY_N - 1 - (32 >> (3 * (s - 1) + j)))))
                begin
                    nx_next[s] = nx_next[s] <<< (32 >> (3 * (s - 1) + j));
                    ny_next[s] = ny_next[s] <<< (32 >> (3 * (s - 1) + j));
                    nm_next[s] = nm_next[s] << (32 >> (3 * (s - 1) + j));
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            logic signed [XY_W-1:0] xi;
            logic signed [XY_W-1:0] yi;
            if (i == 0)
            begin
                xi = {{(XY_W-XY_N){nx_reg[2][XY_N-1]}}, nx_reg[2]};
                yi = {{(XY_W-XY_N){ny_reg[2][XY_N-1]}}, ny_reg[2]};
            end
            else
            begin
                xi = x_reg[i-1];
                yi = y_reg[i-1];
            end
            if (yi >= 0)
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = z_reg[i+2] + ATAN_TAB[i];
            end
            else
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = z_reg[i+2] - ATAN_TAB[i];
            end
        end
    end

    always_comb
    begin
        z_clamp = z_reg[ZN-1];
        if (z_clamp > DEG180)
        begin
            z_clamp = DEG180;
        end
        if (z_clamp < -DEG180)
        begin
            z_clamp = -DEG180;
        end
        if (spec_reg[ZN-1])
        begin
            z_clamp = sneg_reg[ZN-1] ? DEG180 : '0;
        end
        z_round    = z_clamp + Z_W'(1 <<< (ROUND_SH - 1));
        angle_next = z_round[ROUND_SH+ANG_W-1:ROUND_SH];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg[0]   <= f_x;
            ny_reg[0]   <= f_y;
            nm_reg[0]   <= (mag_x > mag_y) ? mag_x : mag_y;
            z_reg[0]    <= f_z;
            spec_reg[0] <= (sin_val == '0);
            sneg_reg[0] <= (cos_val < 0);
            for (int s = 1; s < 3; s++)
            begin
                nx_reg[s] <= nx_next[s];
                ny_reg[s] <= ny_next[s];
                nm_reg[s] <= nm_next[s];
            end
            for (int s = 1; s < 3; s++)
            begin
                z_reg[s] <= z_reg[s-1];
            end
            for (int s = 1; s < ZN; s++)
            begin
                spec_reg[s] <= spec_reg[s-1];
                sneg_reg[s] <= sneg_reg[s-1];
            end
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i]   <= x_next[i];
                y_reg[i]   <= y_next[i];
                z_reg[i+3] <= z_next[i];
            end
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// File: hdl/qte_checker.sv
// ============================================================================
// Quaternion to Euler angle port checker
// Watches the ports of the core for output stability, stall behavior and
// the legal range of the angle results.
// ============================================================================
module qte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] roll_deg,
    input logic signed [14:0] pitch_deg,
    input logic signed [15:0] yaw_deg,
    input logic               pitch_saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_deg)
            && $stable(pitch_deg) && $stable(yaw_deg) && $stable(pitch_saturated))
        else $error("output transaction changed while stalled");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while the pipeline is stalled");

    a_sat_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pitch_saturated |-> pitch_deg == 15'sd11520
            || pitch_deg == -15'sd11520)
        else $error("saturated pitch is not at 90 degrees");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_deg <= 16'sd23040 && roll_deg >= -16'sd23040
            && yaw_deg <= 16'sd23040 && yaw_deg >= -16'sd23040
            && pitch_deg <= 15'sd11520 && pitch_deg >= -15'sd11520)
        else $error("angle result out of range");

endmodule

bind quaternion_to_euler_degrees_core qte_checker u_qte_checker (.*);

// File: verif/quaternion_to_euler_degrees_core_test.sv
`timescale 1ns / 1ps
// ============================================================================
// Quaternion to Euler angle core testbench
// Drives quaternions through the valid/ready input, predicts roll, pitch, yaw
// and the pitch clamp flag with a bit-exact CORDIC model, and compares every
// output transaction in order. Covers axis and sign extremes, saturation,
// unit and random quaternions, random idling on both sides and a long
// output stall that fills the pipeline.
// ============================================================================
module quaternion_to_euler_degrees_core_test;

    import qte_pkg::*;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
        logic               sat;
    } euler_t;

    localparam longint ANGLE_180 = 64'sd180 <<< 16;
    localparam longint ANGLE_90  = 64'sd90 <<< 16;
    localparam int     STALL_LIMIT = 20000;
    localparam int     HOLD_LEN = 150;

    localparam longint ATAN_DEG [0:21] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] roll_deg;
    logic signed [14:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic               pitch_saturated;

    euler_t expected_angles[$];
    int     error_count;
    int     idle_count;
    bit     sender_idles;
    bit     receiver_idles;
    int     hold_cycles;
    bit     hold_request;
    bit     hold_started;

    quaternion_to_euler_degrees_core i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .quat_x          (quat_x),
        .quat_y          (quat_y),
        .quat_z          (quat_z),
        .quat_w          (quat_w),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .roll_deg        (roll_deg),
        .pitch_deg       (pitch_deg),
        .yaw_deg         (yaw_deg),
        .pitch_saturated (pitch_saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint vector_atan2(longint s, longint c);
        longint px;
        longint py;
        longint ang;
        longint mx;
        longint sx;
        longint sy;
        px = c;
        py = s;
        ang = 0;
        if (py == 0)
            return (px < 0) ? ANGLE_180 : 0;
        if (px < 0)
        begin
            ang = (py >= 0) ? ANGLE_180 : -ANGLE_180;
            px = -px;
            py = -py;
        end
        mx = (px > (py < 0 ? -py : py)) ? px : (py < 0 ? -py : py);
        while (mx < (64'sd1 <<< 40))
        begin
            px = px * 2;
            py = py * 2;
            mx = mx * 2;
        end
        for (int i = 0; i < 22; i++)
        begin
            sx = px >>> i;
            sy = py >>> i;
            if (py >= 0)
            begin
                px = px + sy;
                py = py - sx;
                ang = ang + ATAN_DEG[i];
            end
            else
            begin
                px = px - sy;
                py = py + sx;
                ang = ang - ATAN_DEG[i];
            end
        end
        if (ang > ANGLE_180)
            ang = ANGLE_180;
        if (ang < -ANGLE_180)
            ang = -ANGLE_180;
        return ang;
    endfunction

    function automatic longint exact_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint round_angle(longint a);
        return (a + 256) >>> 9;
    endfunction

    function automatic euler_t predict_euler(logic signed [15:0] qx, logic signed [15:0] qy,
                                             logic signed [15:0] qz, logic signed [15:0] qw);
        longint one;
        longint x;
        longint y;
        longint z;
        longint w;
        longint sinp;
        longint pitch;
        longint r;
        longint p;
        longint yw;
        euler_t e;
        one = 64'sd1 <<< 28;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        r = vector_atan2(2 * (w * x + y * z), one - 2 * (x * x + y * y));
        yw = vector_atan2(2 * (w * z + x * y), one - 2 * (y * y + z * z));
        sinp = 2 * (w * y - z * x);
        e.sat = 1'b0;
        if (((sinp < 0) ? -sinp : sinp) >= one)
        begin
            e.sat = 1'b1;
            pitch = (sinp < 0) ? -ANGLE_90 : ANGLE_90;
        end
        else
        begin
            pitch = vector_atan2(sinp,
                exact_root((64'd1 << 56) - longint'(sinp * sinp)));
            if (pitch > ANGLE_90)
                pitch = ANGLE_90;
            if (pitch < -ANGLE_90)
                pitch = -ANGLE_90;
        end
        p = round_angle(pitch);
        r = round_angle(r);
        yw = round_angle(yw);
        e.roll = r[15:0];
        e.pitch = p[14:0];
        e.yaw = yw[15:0];
        return e;
    endfunction

    task automatic send_quaternion(logic signed [15:0] qx, logic signed [15:0] qy,
                                   logic signed [15:0] qz, logic signed [15:0] qw);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        quat_w <= qw;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_angles = {expected_angles, predict_euler(qx, qy, qz, qw)};
    endtask

    task automatic send_random_unit();
        real a;
        real b;
        real c;
        real d;
        real n;
        a = real'($signed($urandom_range(0, 2000)) - 1000);
        b = real'($signed($urandom_range(0, 2000)) - 1000);
        c = real'($signed($urandom_range(0, 2000)) - 1000);
        d = real'($signed($urandom_range(0, 2000)) - 1000);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0;
            n = 1.0;
        end
        send_quaternion(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                        16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    task automatic test_directed();
        send_quaternion(0, 0, 0, 0);
        send_quaternion(0, 0, 0, 16384);
        send_quaternion(16384, 0, 0, 0);
        send_quaternion(0, 16384, 0, 0);
        send_quaternion(0, 0, 16384, 0);
        send_quaternion(0, 0, 0, -16384);
        send_quaternion(11585, 0, 0, 11585);
        send_quaternion(0, 11585, 0, 11585);
        send_quaternion(0, -11585, 0, 11585);
        send_quaternion(0, 0, 11585, 11585);
        send_quaternion(0, 11586, 0, 11586);
        send_quaternion(-11586, 0, 11586, 0);
        send_quaternion(32767, 32767, 32767, 32767);
        send_quaternion(-32768, -32768, -32768, -32768);
        send_quaternion(-32768, 32767, -32768, 32767);
        send_quaternion(32767, -32768, 0, 1);
        send_quaternion(1, 1, 1, 1);
        send_quaternion(-1, 0, 0, 0);
        send_quaternion(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
        send_quaternion(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
        send_quaternion(8192, 8192, 8192, 8192);
    endtask

    task automatic test_random_idling();
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        for (int i = 0; i < 1000; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_quaternion(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
            else
                send_random_unit();
        end
    endtask

    task automatic test_output_stall();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 200; i++)
            send_random_unit();
    endtask

    task automatic test_streaming();
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        for (int i = 0; i < 500; i++)
        begin
            if (i % 5 == 0)
                send_quaternion(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
            else
                send_random_unit();
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cycles <= 0;
            hold_started <= 1'b0;
        end
        else if (hold_request && !hold_started)
        begin
            out_ready <= 1'b0;
            hold_cycles <= HOLD_LEN - 1;
            hold_started <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (receiver_idles)
            out_ready <= ($urandom_range(0, 3) != 0);
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("Output transaction with no quaternion outstanding.");
                error_count++;
            end
            else
            begin
                e = expected_angles.pop_front();
                if (roll_deg !== e.roll)
                begin
                    $error("roll_deg: expected %0d, actual %0d", e.roll, roll_deg);
                    error_count++;
                end
                if (pitch_deg !== e.pitch)
                begin
                    $error("pitch_deg: expected %0d, actual %0d", e.pitch, pitch_deg);
                    error_count++;
                end
                if (yaw_deg !== e.yaw)
                begin
                    $error("yaw_deg: expected %0d, actual %0d", e.yaw, yaw_deg);
                    error_count++;
                end
                if (pitch_saturated !== e.sat)
                begin
                    $error("pitch_saturated: expected %0d, actual %0d", e.sat,
                           pitch_saturated);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        quat_w = '0;
        hold_request = 1'b0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_idling();
        test_output_stall();
        test_streaming();
        in_valid <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && expected_angles.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: quaternion_to_euler_degrees_core.f
hdl/qte_pkg.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_degrees_core.sv
hdl/qte_checker.sv
verif/quaternion_to_euler_degrees_core_test.sv
